// File: rtl/assert_macros.svh
// Assertion helpers used by the RTL.
// ASSERT_ALWAYS checks a condition at every clock edge outside reset.
// ASSERT_NEXT checks that a condition in one cycle implies another in the next.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/dldq_pkg.sv
package dldq_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int TASK_W    = 4;
    localparam int DELTA_W   = 16;
    localparam int SUM_W     = DELTA_W + 1;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_INSERT,
        ST_SET_HEAD,
        ST_POP
    } store_op_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    // Command from the sequencer to the entry store
    typedef struct packed {
        store_op_t            op;
        logic [IDX_W-1:0]     pos;
        logic [TASK_W-1:0]    task_id;
        logic [DELTA_W-1:0]   own;
        logic [DELTA_W-1:0]   diff;
    } store_cmd_t;

    // Status from the entry store to the sequencer
    typedef struct packed {
        logic [CNT_W-1:0]     count;
        logic [DELTA_W-1:0]   rd_delta;
        logic [TASK_W-1:0]    head_task;
        logic [DELTA_W-1:0]   head_delta;
        logic [DELTA_W-1:0]   next_delta;
    } store_stat_t;

    // One release toward the output register
    typedef struct packed {
        logic                 valid;
        logic [TASK_W-1:0]    task_id;
        logic                 last;
    } release_t;

endpackage

// File: rtl/dldq_alu.sv
module dldq_alu (
    input  dldq_pkg::alu_op_t           op,
    input  logic [dldq_pkg::SUM_W-1:0]  a,
    input  logic [dldq_pkg::SUM_W-1:0]  b,
    output logic [dldq_pkg::SUM_W-1:0]  y
);
    import dldq_pkg::*;

    always_comb begin
        case (op)
            ALU_SUB: y = a - b;
            default: y = a + b;
        endcase
    end

endmodule

// File: rtl/dldq_store.sv
`include "assert_macros.svh"

module dldq_store (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dldq_pkg::store_cmd_t   cmd,
    input  logic [dldq_pkg::IDX_W-1:0] rd_pos,
    output dldq_pkg::store_stat_t  stat
);
    import dldq_pkg::*;

    logic [TASK_W-1:0]  task_reg  [MAX_TASKS];
    logic [DELTA_W-1:0] delta_reg [MAX_TASKS];
    logic [CNT_W-1:0]   count_reg;

    always_comb begin
        stat.count      = count_reg;
        stat.rd_delta   = delta_reg[rd_pos];
        stat.head_task  = task_reg[0];
        stat.head_delta = delta_reg[0];
        stat.next_delta = delta_reg[1];
    end

    // entry payload: no reset, entries at or above count are never observed
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            ST_INSERT: begin
                if (cmd.pos == '0) begin
                    task_reg[0]  <= cmd.task_id;
                    delta_reg[0] <= cmd.own;
                end
                for (int k = 1; k < MAX_TASKS; k++) begin
                    if (IDX_W'(k) == cmd.pos) begin
                        task_reg[k]  <= cmd.task_id;
                        delta_reg[k] <= cmd.own;
                    end else if (IDX_W'(k) > cmd.pos) begin
                        task_reg[k]  <= task_reg[k-1];
                        delta_reg[k] <= (IDX_W'(k - 1) == cmd.pos) ? cmd.diff
                                                                    : delta_reg[k-1];
                    end
                end
            end
            ST_SET_HEAD: begin
                delta_reg[0] <= cmd.own;
            end
            ST_POP: begin
                for (int k = 0; k < MAX_TASKS - 1; k++) begin
                    task_reg[k]  <= task_reg[k+1];
                    delta_reg[k] <= delta_reg[k+1];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            case (cmd.op)
                ST_INSERT: count_reg <= count_reg + 1'b1;
                ST_POP:    count_reg <= count_reg - 1'b1;
                default:   count_reg <= count_reg;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(MAX_TASKS))
    `ASSERT_ALWAYS(a_insert_room, aclk, aresetn, cmd.op != ST_INSERT || count_reg < CNT_W'(MAX_TASKS))
    `ASSERT_ALWAYS(a_pop_nonempty, aclk, aresetn, cmd.op != ST_POP || count_reg != '0)
    `ASSERT_NEXT(a_pop_count, aclk, aresetn, cmd.op == ST_POP, count_reg == CNT_W'($past(count_reg) - 1'b1))

endmodule

// File: rtl/dldq_ctrl.sv
module dldq_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_kind,
    input  logic [dldq_pkg::TASK_W-1:0] in_task_id,
    input  logic [dldq_pkg::DELTA_W-1:0] in_delay,
    input  logic                        slot_free,
    output dldq_pkg::release_t          rel,
    input  dldq_pkg::store_stat_t       stat,
    output dldq_pkg::store_cmd_t        cmd,
    output logic [dldq_pkg::IDX_W-1:0]  rd_pos
);
    import dldq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_OWN,
        S_DIFF,
        S_PLACE,
        S_DEC,
        S_SCAN
    } state_t;

    state_t             state_reg, state_next;
    logic [DELTA_W-1:0] want_reg, want_next;
    logic [TASK_W-1:0]  tid_reg, tid_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [DELTA_W-1:0] before_reg, before_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [DELTA_W-1:0] rd_delta_reg, rd_delta_next;
    logic [DELTA_W-1:0] own_reg, own_next;
    logic [DELTA_W-1:0] diff_reg, diff_next;

    alu_op_t            alu_op;
    logic [SUM_W-1:0]   alu_a, alu_b, alu_y;
    logic               head_due;

    dldq_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign rd_pos   = pos_reg[IDX_W-1:0];
    assign head_due = (stat.count != '0) && (stat.head_delta == '0);

    // operand select for the shared adder
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            S_WALK: begin
                alu_a = sum_reg;
                alu_b = {1'b0, stat.rd_delta};
            end
            S_OWN: begin
                alu_op = ALU_SUB;
                alu_a  = {1'b0, want_reg};
                alu_b  = {1'b0, before_reg};
            end
            S_DIFF: begin
                alu_op = ALU_SUB;
                alu_a  = {1'b0, rd_delta_reg};
                alu_b  = {1'b0, own_reg};
            end
            S_DEC: begin
                alu_op = ALU_SUB;
                alu_a  = {1'b0, stat.head_delta};
                alu_b  = SUM_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        want_next     = want_reg;
        tid_next      = tid_reg;
        sum_next      = sum_reg;
        before_next   = before_reg;
        pos_next      = pos_reg;
        rd_delta_next = rd_delta_reg;
        own_next      = own_reg;
        diff_next     = diff_reg;
        cmd           = '0;
        cmd.op        = ST_NONE;
        rel           = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    if (in_kind == KIND_INSERT) begin
                        // drop the insert when the list is full
                        if (stat.count < CNT_W'(MAX_TASKS)) begin
                            want_next   = (in_delay == '0) ? DELTA_W'(1) : in_delay;
                            tid_next    = in_task_id;
                            sum_next    = '0;
                            before_next = '0;
                            pos_next    = '0;
                            state_next  = S_WALK;
                        end
                    end else if (stat.count != '0) begin
                        state_next = S_DEC;
                    end
                end
            end
            S_WALK: begin
                if (pos_reg == stat.count) begin
                    state_next = S_OWN;
                end else if ({1'b0, want_reg} < alu_y) begin
                    rd_delta_next = stat.rd_delta;
                    state_next    = S_OWN;
                end else begin
                    sum_next    = alu_y;
                    before_next = alu_y[DELTA_W-1:0];
                    pos_next    = pos_reg + 1'b1;
                end
            end
            S_OWN: begin
                own_next   = alu_y[DELTA_W-1:0];
                state_next = S_DIFF;
            end
            S_DIFF: begin
                diff_next  = alu_y[DELTA_W-1:0];
                state_next = S_PLACE;
            end
            S_PLACE: begin
                cmd.op      = ST_INSERT;
                cmd.pos     = pos_reg[IDX_W-1:0];
                cmd.task_id = tid_reg;
                cmd.own     = own_reg;
                cmd.diff    = diff_reg;
                state_next  = S_IDLE;
            end
            S_DEC: begin
                if (stat.head_delta != '0) begin
                    cmd.op  = ST_SET_HEAD;
                    cmd.own = alu_y[DELTA_W-1:0];
                end
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (!head_due) begin
                    state_next = S_IDLE;
                end else if (slot_free) begin
                    rel.valid   = 1'b1;
                    rel.task_id = stat.head_task;
                    rel.last    = (stat.count == CNT_W'(1)) || (stat.next_delta != '0);
                    cmd.op      = ST_POP;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        want_reg     <= want_next;
        tid_reg      <= tid_next;
        sum_reg      <= sum_next;
        before_reg   <= before_next;
        pos_reg      <= pos_next;
        rd_delta_reg <= rd_delta_next;
        own_reg      <= own_next;
        diff_reg     <= diff_next;
    end

endmodule

// File: rtl/delta_list_delay_queue_top.sv
// Delta-list delay queue.
// Input channel s_*: one transfer per item. s_kind selects a tick or an insert;
// an insert carries s_task_id and s_delay (0 counts as 1 tick). Inserts into a
// full list (16 entries) are dropped and produce no transfer on the output.
// Output channel m_*: one transfer per released task, m_last set on the final
// release of a tick. A tick with nothing due produces no output transfer.
// Timing: all delta arithmetic runs through one shared 17-bit adder under a small
// sequencer, so s_ready is high only while the sequencer is idle.
// An insert walks the entries before its slot (at most 15), one entry per
// cycle, then computes its own delta and its follower's, then writes the list.
// A tick decrements the head delta, then releases each due task in turn while
// the output register can take it. A tick on an empty list and a dropped insert
// leave the sequencer idle. Each release is loaded into the output register.
// A stall on m_ready holds the pending release in the output register and
// suspends further releases; a new item can be accepted once the sequencer is
// back to idle even while the last release still waits.
// Reset (aresetn low, synchronous) empties the list and clears m_valid.
module delta_list_delay_queue_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [dldq_pkg::TASK_W-1:0]  s_task_id,
    input  logic [dldq_pkg::DELTA_W-1:0] s_delay,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [dldq_pkg::TASK_W-1:0]  m_released_task,
    output logic                         m_last
);
    import dldq_pkg::*;

    store_cmd_t         cmd;
    store_stat_t        stat;
    release_t           rel;
    logic [IDX_W-1:0]   rd_pos;
    logic               slot_free;

    logic               m_valid_reg;
    logic [TASK_W-1:0]  m_task_reg;
    logic               m_last_reg;

    // output slot can take a release when empty or draining this cycle
    assign slot_free = !m_valid_reg || m_ready;

    dldq_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_kind    (s_kind),
        .in_task_id (s_task_id),
        .in_delay   (s_delay),
        .slot_free  (slot_free),
        .rel        (rel),
        .stat       (stat),
        .cmd        (cmd),
        .rd_pos     (rd_pos)
    );

    dldq_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rd_pos  (rd_pos),
        .stat    (stat)
    );

    // output register: load a release, drop valid once the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rel.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (rel.valid) begin
            m_task_reg <= rel.task_id;
            m_last_reg <= rel.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_released_task = m_task_reg;
    assign m_last          = m_last_reg;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dldq_pkg::*;

    // Cycles with no transfer on either channel before the run is declared hung.
    // The longest quiet stretch is the receiver hold-off below, plus a stalled
    // insert walk and sender gaps on top.
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_OFF     = 300;
    localparam int TAIL_CYCLES  = 64;
    localparam int RANDOM_ITEMS = 420;

    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic              last;
    } due_task_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic                s_kind    = KIND_TICK;
    logic [TASK_W-1:0]   s_task_id = '0;
    logic [DELTA_W-1:0]  s_delay   = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic [TASK_W-1:0]   m_released_task;
    logic                m_last;

    // Predicted delta list: identifiers in release order, each delay relative
    // to the entry ahead of it.
    logic [TASK_W-1:0]   list_task  [MAX_TASKS];
    logic [DELTA_W-1:0]  list_delta [MAX_TASKS];
    int                  list_count = 0;

    // Releases predicted at the input transfer, consumed by the output checker.
    due_task_t           pending_releases [$];

    int                  mismatches  = 0;
    int                  idle_cycles = 0;
    int                  hold_cycles = 0;   // set by a test, picked up by the receiver
    bit                  steady_flow = 1'b0; // when set, neither side idles

    delta_list_delay_queue_top uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_task_id       (s_task_id),
        .s_delay         (s_delay),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_released_task (m_released_task),
        .m_last          (m_last)
    );

    always #4 aclk = ~aclk;

    // Place a task in the predicted list. A zero delay counts as one tick, and
    // an equal total delay goes behind the tasks already queued with it.
    function automatic void list_insert(input logic [TASK_W-1:0] id,
                                        input logic [DELTA_W-1:0] dly);
        int unsigned want;
        int unsigned sum;
        int unsigned prior;
        int          pos;
        int          k;
        if (list_count >= MAX_TASKS) return;    // drop on a full list
        want  = (dly == '0) ? 1 : dly;
        sum   = 0;
        prior = 0;
        for (pos = 0; pos < list_count; pos++) begin
            sum += list_delta[pos];
            if (want < sum) break;
            prior = sum;
        end
        if (pos < list_count) begin
            // Open a slot and take our share out of the follower's delta.
            for (k = list_count; k > pos; k--) begin
                list_task[k]  = list_task[k-1];
                list_delta[k] = list_delta[k-1];
            end
            list_delta[pos+1] = DELTA_W'(list_delta[pos+1] - (want - prior));
            list_delta[pos]   = DELTA_W'(want - prior);
        end else begin
            list_delta[pos] = DELTA_W'(want - sum);
        end
        list_task[pos] = id;
        list_count++;
    endfunction

    // Advance the predicted list by one tick and queue every release it causes.
    function automatic void list_tick();
        int        done;
        int        k;
        due_task_t rel;
        if (list_count == 0) return;
        if (list_delta[0] != 0) list_delta[0]--;
        done = 0;
        while (done < list_count && list_delta[done] == 0) begin
            rel.task_id = list_task[done];
            rel.last    = (done + 1 >= list_count) || (list_delta[done+1] != 0);
            pending_releases.push_back(rel);
            done++;
        end
        for (k = done; k < list_count; k++) begin
            list_task[k-done]  = list_task[k];
            list_delta[k-done] = list_delta[k];
        end
        list_count -= done;
    endfunction

    task automatic note_mismatch(input string what, input string expv, input int actv);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %s, got %0d at %0t ns", what, expv, actv, $realtime);
    endtask

    // Offer one item and hold it until the transfer. Valid stays high across
    // back-to-back items; here it drops only when a gap is drawn, and drain_releases also lowers it.
    task automatic send_item(input logic kind, input logic [TASK_W-1:0] id,
                             input logic [DELTA_W-1:0] dly);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_task_id <= id;
        s_delay   <= dly;
        do @(posedge aclk); while (!s_ready);
        if (kind == KIND_INSERT) list_insert(id, dly);
        else list_tick();
    endtask

    // Pause the sender until every predicted release has been seen. Always
    // wait for a clock edge before checking, so the next item never re-raises valid in the
    // step that lowered it.
    task automatic drain_releases();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_releases.size() != 0);
    endtask

    // Empty-list tick, zero delay, top identifier with an all-ones delay.
    task automatic test_special_cases();
        send_item(KIND_TICK,   4'd3,  16'hFFFF);
        send_item(KIND_INSERT, 4'd5,  16'd0);
        send_item(KIND_TICK,   4'd0,  16'd0);
        send_item(KIND_INSERT, 4'd15, 16'hFFFF);
        drain_releases();
    endtask

    // Fill all 16 entries with delays cycling 1 to 3 so that ties line up,
    // release each tie group on its own tick, then tick once with nothing due.
    task automatic test_full_queue();
        for (int k = 0; k < MAX_TASKS - 1; k++)
            send_item(KIND_INSERT, TASK_W'(k), DELTA_W'(k % 3 + 1));
        send_item(KIND_INSERT, 4'd9, 16'd2);
        repeat (4) send_item(KIND_TICK, 4'd0, 16'd0);
        drain_releases();
    endtask

    // Hold the receiver off while the sender keeps offering back to back, so
    // that pending releases stall the sequencer and s_ready drops.
    task automatic test_output_backpressure();
        hold_cycles = HOLD_OFF;
        steady_flow = 1'b1;
        for (int k = 0; k < 12; k++)
            send_item(KIND_INSERT, TASK_W'($urandom_range(0, 15)),
                      DELTA_W'($urandom_range(0, 3)));
        repeat (6) send_item(KIND_TICK, TASK_W'($urandom_range(0, 15)), 16'd0);
        steady_flow = 1'b0;
        drain_releases();
    endtask

    // Mixed ticks and inserts with mostly short delays so the list cycles
    // through empty, busy and full. Switch to no-idle stretches now and then
    // and pause the sender once halfway.
    task automatic test_random_traffic(input int count);
        logic               kind;
        logic [DELTA_W-1:0] dly;
        int                 pick;
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0) steady_flow = ($urandom_range(0, 3) == 0);
            if (n == count / 2) drain_releases();
            kind = ($urandom_range(0, 99) < 52) ? KIND_TICK : KIND_INSERT;
            pick = $urandom_range(0, 99);
            if (pick == 0)     dly = DELTA_W'($urandom_range(0, 65535));
            else if (pick < 8) dly = DELTA_W'($urandom_range(0, 1));
            else               dly = DELTA_W'($urandom_range(0, 20));
            send_item(kind, TASK_W'($urandom_range(0, 15)), dly);
        end
        steady_flow = 1'b0;
    endtask

    // Receiver: check each output transfer against the oldest prediction,
    // then draw how long to hold off before the next one.
    initial begin : release_checker
        int        rx_wait;
        due_task_t want;
        rx_wait = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_releases.size() == 0) begin
                    note_mismatch("release with nothing pending", "none", m_released_task);
                end else begin
                    want = pending_releases.pop_front();
                    if (m_released_task !== want.task_id)
                        note_mismatch("released_task", $sformatf("%0d", want.task_id),
                                      m_released_task);
                    if (m_last !== want.last)
                        note_mismatch("last", $sformatf("%0d", want.last), m_last);
                end
                rx_wait = steady_flow ? 0 : $urandom_range(0, 19);
            end
            if (hold_cycles > 0) begin
                rx_wait     = hold_cycles;
                hold_cycles = 0;
            end
            if (rx_wait > 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("delta_list_delay_queue_top verification failed");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_special_cases();
        test_full_queue();
        test_output_backpressure();
        test_random_traffic(RANDOM_ITEMS);

        // Flush: wait out every release, then let the block settle.
        drain_releases();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_releases.size() != 0) begin
            $display("%0d predicted releases never arrived", pending_releases.size());
            mismatches += pending_releases.size();
        end

        if (mismatches == 0) begin
            $display("delta_list_delay_queue_top verification clean");
        end else begin
            $display("delta_list_delay_queue_top verification failed");
        end
        $finish;
    end

endmodule
